// ===== rtl/arpc_pkg.sv =====
// Shared types and constants for the ARP cache table.
// Holds the table geometry, the entry layout, and the operation and status codes.
// Depends on nothing.
package arpc_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int IP_W = 32;
    localparam int MAC_W = 48;
    localparam int STATUS_W = 3;
    localparam int ENTRY_COUNT_W = 6;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_ADD    = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_ADDED     = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_UNCHANGED = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } t_state;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             kind;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/arp_cache_table.sv =====
// ARP cache table top level: entry RAM, scan sequencer, and result register.
// Throughput: one item at a time; the next item is taken the cycle after the result is loaded.
// The scan reads one RAM entry per cycle and stops at the first entry whose IP matches.
// Reset empties the table at once by clearing the fill count; no clearing pass is needed.
// Depends on arpc_pkg and arpc_ram.
module arp_cache_table (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_op,
    input  logic [arpc_pkg::IP_W-1:0]            i_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]           i_mac_addr,
    input  logic                                 i_entry_kind,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [arpc_pkg::STATUS_W-1:0]        o_status,
    output logic [arpc_pkg::MAC_W-1:0]           o_found_mac,
    output logic                                 o_found_kind,
    output logic [arpc_pkg::ENTRY_COUNT_W-1:0]   o_entry_count
);

    import arpc_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;

    t_op               r_op, n_op;
    logic [IP_W-1:0]   r_key, n_key;
    logic [MAC_W-1:0]  r_mac, n_mac;
    logic              r_kind, n_kind;

    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [MAC_W-1:0]  r_hit_mac, n_hit_mac;
    logic              r_hit_kind, n_hit_kind;

    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [MAC_W-1:0]  r_out_mac, n_out_mac;
    logic              r_out_kind, n_out_kind;
    logic [CNT_W-1:0]  r_out_count, n_out_count;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;
    t_entry            w_rdata;
    logic [ENTRY_W-1:0] w_rdata_raw;
    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_match;

    arpc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_rd_idx[IDX_W-1:0]),
        .o_rdata(w_rdata_raw)
    );

    assign w_rdata    = t_entry'(w_rdata_raw);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_match    = r_pend && (w_rdata.ip == r_key);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_op         = r_op;
        n_key        = r_key;
        n_mac        = r_mac;
        n_kind       = r_kind;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_mac    = r_hit_mac;
        n_hit_kind   = r_hit_kind;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_mac    = r_out_mac;
        n_out_kind   = r_out_kind;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = r_hit_idx;
        w_wdata      = '{ip: r_key, mac: r_mac, kind: r_kind};

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_op     = t_op'(i_op);
                    n_key    = i_ip_addr;
                    n_mac    = i_mac_addr;
                    n_kind   = i_entry_kind;
                    n_hit    = 1'b0;
                    n_rd_idx = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_pend_idx;
                    n_hit_mac  = w_rdata.mac;
                    n_hit_kind = w_rdata.kind;
                    n_state    = S_RESOLVE;
                end else if (r_rd_idx == r_count) begin
                    if (!r_pend) begin
                        n_state = S_RESOLVE;
                    end
                end else begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx   = r_rd_idx + 1'b1;
                end
            end
            S_RESOLVE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mac   = '0;
                    n_out_kind  = 1'b0;
                    n_state     = S_IDLE;
                    if (r_op == OP_LOOKUP) begin
                        if (r_hit) begin
                            n_out_status = ST_HIT;
                            n_out_mac    = r_hit_mac;
                            n_out_kind   = r_hit_kind;
                        end else begin
                            n_out_status = ST_MISS;
                        end
                    end else if (r_hit) begin
                        if ((r_mac == r_hit_mac) || (r_mac == '0)) begin
                            n_out_status = ST_UNCHANGED;
                        end else begin
                            n_out_status = ST_UPDATED;
                            w_we         = 1'b1;
                        end
                    end else if (r_count == CNT_W'(TABLE_ENTRIES)) begin
                        n_out_status = ST_FULL;
                    end else begin
                        n_out_status = ST_ADDED;
                        w_we         = 1'b1;
                        w_waddr      = r_count[IDX_W-1:0];
                        n_count      = r_count + 1'b1;
                    end
                    n_out_count = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_op         <= n_op;
        r_key        <= n_key;
        r_mac        <= n_mac;
        r_kind       <= n_kind;
        r_hit_idx    <= n_hit_idx;
        r_hit_mac    <= n_hit_mac;
        r_hit_kind   <= n_hit_kind;
        r_out_status <= n_out_status;
        r_out_mac    <= n_out_mac;
        r_out_kind   <= n_out_kind;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_mac   = r_out_mac;
    assign o_found_kind  = r_out_kind;
    assign o_entry_count = ENTRY_COUNT_W'(r_out_count);

`ifndef ASSERT_OFF
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> ((r_count == $past(r_count) + 1'b1) && ($past(r_state) == S_RESOLVE)))
        else $error("Fill count changed outside an add.");

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (CNT_W'(r_pend_idx) < r_count))
        else $error("Scan compared an entry beyond the fill count.");

    a_result_from_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == S_RESOLVE))
        else $error("Result appeared without a resolve step.");
`endif

endmodule

// ===== rtl/arpc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the cache entry store; depends on nothing.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for arp_cache_table: directed and random lookups and adds,
// checked against an in-bench model of the bounded IP-to-MAC table, with random stalls.
// Depends on arpc_pkg and the arp_cache_table RTL.
module testbench;
    import arpc_pkg::*;

    typedef struct packed {
        t_op              op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             kind;
    } arp_item_t;

    typedef struct packed {
        t_status                  status;
        logic [MAC_W-1:0]         mac;
        logic                     kind;
        logic [ENTRY_COUNT_W-1:0] count;
    } arp_result_t;

    localparam int RANDOM_ITEMS = 1600;
    localparam int POOL_SIZE = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STUCK_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_op = 1'b0;
    logic [IP_W-1:0] i_ip_addr = '0;
    logic [MAC_W-1:0] i_mac_addr = '0;
    logic i_entry_kind = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [MAC_W-1:0] o_found_mac;
    logic o_found_kind;
    logic [ENTRY_COUNT_W-1:0] o_entry_count;

    arp_item_t pending_items[$];
    arp_result_t expected_results[$];
    arp_item_t next_item;

    logic tbl_valid[TABLE_ENTRIES];
    logic [IP_W-1:0] tbl_ip[TABLE_ENTRIES];
    logic [MAC_W-1:0] tbl_mac[TABLE_ENTRIES];
    logic tbl_kind[TABLE_ENTRIES];
    logic [ENTRY_COUNT_W-1:0] tbl_count = '0;

    logic [IP_W-1:0] pool_ip[POOL_SIZE];
    logic [MAC_W-1:0] pool_mac_a[POOL_SIZE];
    logic [MAC_W-1:0] pool_mac_b[POOL_SIZE];

    int total_items = 0;
    int accepted_count = 0;
    int mismatches = 0;
    int stuck_cycles = 0;
    int hold_left = 0;
    bit pressure_done = 1'b0;
    int send_idle_pct;
    int recv_idle_pct;

    assign send_idle_pct = (accepted_count < total_items / 3) ? 19 :
                           (accepted_count < 2 * total_items / 3) ? 73 : 0;
    assign recv_idle_pct = (accepted_count < total_items / 3) ? 73 :
                           (accepted_count < 2 * total_items / 3) ? 19 : 0;

    arp_cache_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_ip_addr     (i_ip_addr),
        .i_mac_addr    (i_mac_addr),
        .i_entry_kind  (i_entry_kind),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found_mac   (o_found_mac),
        .o_found_kind  (o_found_kind),
        .o_entry_count (o_entry_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic arp_result_t resolve_arp_item(arp_item_t it);
        arp_result_t r;
        int hit_idx;
        int free_idx;
        hit_idx = -1;
        free_idx = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_ip[i] == it.ip && hit_idx < 0) begin
                hit_idx = i;
            end
            if (!tbl_valid[i] && free_idx < 0) begin
                free_idx = i;
            end
        end
        r = '0;
        if (it.op == OP_LOOKUP) begin
            if (hit_idx >= 0) begin
                r.status = ST_HIT;
                r.mac = tbl_mac[hit_idx];
                r.kind = tbl_kind[hit_idx];
            end else begin
                r.status = ST_MISS;
            end
        end else if (hit_idx >= 0) begin
            if (it.mac == tbl_mac[hit_idx] || it.mac == '0) begin
                r.status = ST_UNCHANGED;
            end else begin
                tbl_mac[hit_idx] = it.mac;
                tbl_kind[hit_idx] = it.kind;
                r.status = ST_UPDATED;
            end
        end else if (free_idx < 0) begin
            r.status = ST_FULL;
        end else begin
            tbl_valid[free_idx] = 1'b1;
            tbl_ip[free_idx] = it.ip;
            tbl_mac[free_idx] = it.mac;
            tbl_kind[free_idx] = it.kind;
            tbl_count = tbl_count + 1'b1;
            r.status = ST_ADDED;
        end
        r.count = tbl_count;
        return r;
    endfunction

    task automatic queue_item(t_op op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                              logic kind);
        arp_item_t it;
        it.op = op;
        it.ip = ip;
        it.mac = mac;
        it.kind = kind;
        pending_items.push_back(it);
    endtask

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        mismatches++;
        $display("mismatch at %0t: %s expected %0h got %0h", $time, field, want, got);
    endtask

    // Driver: a new transfer is offered only once the previous one has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                i_op <= next_item.op;
                i_ip_addr <= next_item.ip;
                i_mac_addr <= next_item.mac;
                i_entry_kind <= next_item.kind;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            next_item_check: begin
                arp_item_t it;
                it.op = t_op'(i_op);
                it.ip = i_ip_addr;
                it.mac = i_mac_addr;
                it.kind = i_entry_kind;
                expected_results.push_back(resolve_arp_item(it));
                accepted_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!pressure_done && accepted_count >= total_items - 150) begin
            pressure_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", 64'd0, 64'(o_status));
            end else begin
                check_fields: begin
                    arp_result_t want;
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch("status", 64'(want.status), 64'(o_status));
                    end
                    if (o_found_mac !== want.mac) begin
                        report_mismatch("found_mac", 64'(want.mac), 64'(o_found_mac));
                    end
                    if (o_found_kind !== want.kind) begin
                        report_mismatch("found_kind", 64'(want.kind), 64'(o_found_kind));
                    end
                    if (o_entry_count !== want.count) begin
                        report_mismatch("entry_count", 64'(want.count),
                                        64'(o_entry_count));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int k;
        int r;
        logic [IP_W-1:0] ip;
        logic [MAC_W-1:0] mac;
        t_op op;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i] = '0;
            tbl_mac[i] = '0;
            tbl_kind[i] = 1'b0;
        end

        // Lookups on an empty table, then the extremes of address and MAC.
        queue_item(OP_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        queue_item(OP_ADD, 32'h0000_0000, 48'h0, 1'b0);
        queue_item(OP_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
        queue_item(OP_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0);
        // Same MAC with another type, and an all-zero MAC, both leave the entry alone.
        queue_item(OP_ADD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_item(OP_ADD, 32'hFFFF_FFFF, 48'h0, 1'b0);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0);
        queue_item(OP_ADD, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 1'b0);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1);
        queue_item(OP_ADD, 32'h0000_0000, 48'h8000_0000_0001, 1'b1);
        queue_item(OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_item(OP_LOOKUP, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
        queue_item(OP_ADD, 32'h8000_0001, 48'h0000_0000_0001, 1'b0);
        queue_item(OP_LOOKUP, 32'h8000_0001, 48'h0, 1'b0);
        queue_item(OP_ADD, 32'h8000_0001, 48'h0000_0000_0001, 1'b1);

        // A small address pool keeps hits and updates common and overfills the table.
        pool_ip[0] = 32'h0000_0000;
        pool_ip[1] = 32'hFFFF_FFFF;
        pool_mac_a[0] = 48'h8000_0000_0001;
        pool_mac_b[0] = 48'h0000_0000_0001;
        pool_mac_a[1] = 48'h1234_5678_9ABC;
        pool_mac_b[1] = 48'hFFFF_FFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            pool_ip[i] = $urandom;
            pool_mac_a[i] = {16'($urandom), 32'($urandom)};
            pool_mac_b[i] = {16'($urandom), 32'($urandom)};
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            k = $urandom_range(POOL_SIZE - 1);
            ip = ($urandom_range(99) < 70) ? pool_ip[k] : 32'($urandom);
            op = ($urandom_range(99) < 45) ? OP_ADD : OP_LOOKUP;
            r = $urandom_range(7);
            case (r)
                0: mac = '0;
                1, 2: mac = pool_mac_a[k];
                3: mac = pool_mac_b[k];
                4: mac = '1;
                default: mac = {16'($urandom), 32'($urandom)};
            endcase
            queue_item(op, ip, mac, 1'($urandom));
        end
        total_items = pending_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
